// ----- sv/tcgr_pkg.sv -----
`timescale 1ns / 1ps

package tcgr_pkg;

   // Text geometry
   localparam int MAX_COLS     = 80;
   localparam int MAX_ROWS     = 25;
   localparam int GLYPH_HEIGHT = 16;
   localparam int GLYPH_COUNT  = 256;
   localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);

   // Field widths
   localparam int OFFSET_W = 11;
   localparam int COLS_W   = 7;
   localparam int MARGIN_W = 11;
   localparam int STRIDE_W = 14;
   localparam int ADDR_W   = 25;
   localparam int QUAD_W   = 64;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 14;

   typedef enum logic {
      OP_PUT_CHAR = 1'b0,
      OP_LOAD_ROW = 1'b1
   } op_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_FB_READY    = 3'd0,
      CSR_TEXT_COLS   = 3'd1,
      CSR_X_MARGIN    = 3'd2,
      CSR_Y_MARGIN    = 3'd3,
      CSR_LINE_STRIDE = 3'd4
   } csr_index_type;

   // Fixed 16-entry RGB565 palette
   function automatic logic [15:0] palette565(input logic [3:0] idx);
      logic [15:0] c;
      unique case (idx)
         4'd0:  c = 16'h0000;
         4'd1:  c = 16'h001f;
         4'd2:  c = 16'h07e0;
         4'd3:  c = 16'h07ff;
         4'd4:  c = 16'hf800;
         4'd5:  c = 16'hf81f;
         4'd6:  c = 16'h3800;
         4'd7:  c = 16'hc618;
         4'd8:  c = 16'hc618;
         4'd9:  c = 16'h001f;
         4'd10: c = 16'h07e0;
         4'd11: c = 16'h07ff;
         4'd12: c = 16'hf800;
         4'd13: c = 16'hf81f;
         4'd14: c = 16'hffe0;
         default: c = 16'hffff;
      endcase
      return c;
   endfunction

   // Four pixels from a nibble; bit 3 is the leftmost pixel, placed in bits 15..0
   function automatic logic [QUAD_W-1:0] make_quad(input logic [3:0] bits,
                                                   input logic [15:0] fg,
                                                   input logic [15:0] bg);
      logic [QUAD_W-1:0] q;
      q = '0;
      for (int p = 0; p < 4; p++) begin
         q[16*p +: 16] = bits[3-p] ? fg : bg;
      end
      return q;
   endfunction

endpackage

// ----- sv/tcgr_channels.sv -----
`timescale 1ns / 1ps

interface tcgr_req_if;
   import tcgr_pkg::*;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [OFFSET_W-1:0] cell_offset;
   logic [7:0]          char_code;
   logic [7:0]          attribute;
   logic [3:0]          glyph_row;
   logic [7:0]          font_bits;

   modport source (output valid, operation, cell_offset, char_code, attribute,
                   glyph_row, font_bits, input ready);
   modport sink   (input valid, operation, cell_offset, char_code, attribute,
                   glyph_row, font_bits, output ready);
endinterface

interface tcgr_rsp_if;
   import tcgr_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] byte_address;
   logic [QUAD_W-1:0] pixel_quad;
   logic              last;

   modport source (output valid, byte_address, pixel_quad, last, input ready);
   modport sink   (input valid, byte_address, pixel_quad, last, output ready);
endinterface

interface tcgr_csr_if;
   import tcgr_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/text_cell_glyph_renderer_unit.sv -----
`timescale 1ns / 1ps
// Text-mode character generator, 8x16 glyphs, RGB565 output.
// req_ch  : items with operation, cell_offset, char_code, attribute, glyph_row,
//           font_bits. A load_font_row item writes one glyph row in the cycle
//           it is accepted and produces nothing. A put_char item produces 32
//           rsp_ch items (two four-pixel halves per glyph row, top to bottom),
//           the last one marked, or nothing while framebuffer_ready is 0.
// rsp_ch  : byte_address, pixel_quad (leftmost pixel in bits 15..0), last.
// csr_ch  : register writes, always ready; write only while the block is idle.
// Sequence: a put_char runs a bit-serial offset division, then scaling, the stride
// multiply and the base add, then one result per cycle from the glyph memory read
// pipeline while rsp_ch does not stall. The next item is accepted once the last
// result sits in the output register. Load items are accepted one per cycle.
// A stall on rsp_ch holds the output register and freezes the row counter;
// the glyph memory re-reads the same row, so no result is lost.
// Reset (synchronous) returns to idle, empties the output register and loads
// the register defaults; the glyph memory is not cleared and rows never
// loaded read back as arbitrary data.
module text_cell_glyph_renderer_unit
   import tcgr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tcgr_req_if.sink   req_ch,
   tcgr_rsp_if.source rsp_ch,
   tcgr_csr_if.sink   csr_ch
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_SCALE  = 6'b000100,
      ST_MULT   = 6'b001000,
      ST_BASE   = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   localparam int YPIX_W = OFFSET_W + 5;
   localparam int XOFF_W = MARGIN_W + 2;
   localparam int PROD_W = YPIX_W + STRIDE_W;

   // Configuration registers
   logic                fb_ready_ff;
   logic [COLS_W-1:0]   text_cols_ff;
   logic [MARGIN_W-1:0] x_margin_ff;
   logic [MARGIN_W-1:0] y_margin_ff;
   logic [STRIDE_W-1:0] stride_ff;

   // Control and datapath registers
   state_type           state_ff, state_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [COLS_W-1:0]   cols_ff, cols_in;
   logic [OFFSET_W-1:0] div_ff, div_in;
   logic [COLS_W-1:0]   rem_ff, rem_in;
   logic [7:0]          ch_ff, ch_in;
   logic [15:0]         fg_ff, fg_in;
   logic [15:0]         bg_ff, bg_in;
   logic [YPIX_W-1:0]   ypix_ff, ypix_in;
   logic [XOFF_W-1:0]   xoff_ff, xoff_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;

   // Output register
   logic                out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]   out_addr_ff, out_addr_in;
   logic [QUAD_W-1:0]   out_quad_ff, out_quad_in;
   logic                out_last_ff, out_last_in;

   // Glyph memory
   logic [7:0]          glyph_mem [STORE_DEPTH];
   logic [7:0]          glyph_rd_ff;
   logic [STORE_AW-1:0] rd_addr;

   logic                req_take;
   logic                out_free;
   logic [COLS_W:0]     trial;
   logic                trial_ge;
   logic [COLS_W-1:0]   cols_clamped;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.byte_address = out_addr_ff;
   assign rsp_ch.pixel_quad   = out_quad_ff;
   assign rsp_ch.last         = out_last_ff;

   // Clamp the column count into 1..MAX_COLS
   always_comb begin
      priority if (text_cols_ff == '0) begin
         cols_clamped = COLS_W'(1);
      end else if ({1'b0, text_cols_ff} > (COLS_W+1)'(MAX_COLS)) begin
         cols_clamped = COLS_W'(MAX_COLS);
      end else begin
         cols_clamped = text_cols_ff;
      end
   end

   // One restoring division step per cycle
   assign trial    = {rem_ff, div_ff[OFFSET_W-1]};
   assign trial_ge = trial >= {1'b0, cols_ff};

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cols_in      = cols_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      ch_in        = ch_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      ypix_in      = ypix_ff;
      xoff_in      = xoff_ff;
      prod_in      = prod_ff;
      addr_in      = addr_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_addr_in  = out_addr_ff;
      out_quad_in  = out_quad_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_ch.operation == OP_PUT_CHAR) && fb_ready_ff) begin
               state_in = ST_DIVIDE;
               cnt_in   = '0;
               cols_in  = cols_clamped;
               div_in   = req_ch.cell_offset;
               rem_in   = '0;
               ch_in    = req_ch.char_code;
               fg_in    = palette565(req_ch.attribute[3:0]);
               bg_in    = palette565(req_ch.attribute[7:4]);
            end
         end
         ST_DIVIDE: begin
            div_in = {div_ff[OFFSET_W-2:0], trial_ge};
            rem_in = trial_ge ? COLS_W'(trial - {1'b0, cols_ff}) : trial[COLS_W-1:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(OFFSET_W - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            ypix_in  = {1'b0, div_ff, 4'b0000} + YPIX_W'(y_margin_ff);
            xoff_in  = {(XOFF_W-1)'({rem_ff, 3'b000}) + (XOFF_W-1)'(x_margin_ff), 1'b0};
            state_in = ST_MULT;
         end
         ST_MULT: begin
            prod_in  = ypix_ff * stride_ff;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            addr_in  = prod_ff[ADDR_W-1:0] + ADDR_W'(xoff_ff);
            cnt_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_addr_in  = cnt_ff[0] ? addr_ff + ADDR_W'(8) : addr_ff;
               out_quad_in  = make_quad(cnt_ff[0] ? glyph_rd_ff[3:0] : glyph_rd_ff[7:4],
                                        fg_ff, bg_ff);
               out_last_in  = (cnt_ff == 5'd31);
               cnt_in       = cnt_ff + 5'd1;
               if (cnt_ff[0]) begin
                  addr_in = addr_ff + ADDR_W'(stride_ff);
               end
               if (cnt_ff == 5'd31) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register the glyph row that the next result will use
   assign rd_addr = {ch_ff, cnt_in[4:1]};

   always_ff @(posedge clock) begin
      if (req_take && (req_ch.operation == OP_LOAD_ROW)) begin
         glyph_mem[{req_ch.char_code, req_ch.glyph_row}] <= req_ch.font_bits;
      end
   end

   always_ff @(posedge clock) begin
      glyph_rd_ff <= glyph_mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cols_ff     <= cols_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      ch_ff       <= ch_in;
      fg_ff       <= fg_in;
      bg_ff       <= bg_in;
      ypix_ff     <= ypix_in;
      xoff_ff     <= xoff_in;
      prod_ff     <= prod_in;
      addr_ff     <= addr_in;
      out_addr_ff <= out_addr_in;
      out_quad_ff <= out_quad_in;
      out_last_ff <= out_last_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ready_ff  <= 1'b0;
         text_cols_ff <= COLS_W'(MAX_COLS);
         x_margin_ff  <= '0;
         y_margin_ff  <= '0;
         stride_ff    <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_FB_READY:    fb_ready_ff  <= csr_ch.data[0];
            CSR_TEXT_COLS:   text_cols_ff <= csr_ch.data[COLS_W-1:0];
            CSR_X_MARGIN:    x_margin_ff  <= csr_ch.data[MARGIN_W-1:0];
            CSR_Y_MARGIN:    y_margin_ff  <= csr_ch.data[MARGIN_W-1:0];
            CSR_LINE_STRIDE: stride_ff    <= csr_ch.data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

endmodule
